/* src/sgs_pkg.sv */
// Shared types, constants and Sobel arithmetic for the Sobel gradient stream unit.
package sgs_pkg;

  localparam int PIX_W          = 8;
  localparam int GRAD_W         = 11;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int TRI_W          = 3 * PIX_W;
  localparam int LINE_W         = 2 * PIX_W;
  localparam int RES_SLOTS      = 4;
  localparam int RES_FIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DIRECTION    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    DIR_DX = 1'b0,
    DIR_DY = 1'b1
  } dir_t;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic [TRI_W-1:0]         tri_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic signed [GRAD_W:0]   acc_t;

  typedef struct packed {
    grad_t gradient;
    logic  row_end;
    logic  frame_end;
    logic  last_of_run;
  } res_t;

  // Position of the item held in the compute stage.
  typedef struct packed {
    logic first_col;
    logic row_end;
    logic top_row;
    logic has_older;
    logic last_row;
  } pos_t;

  function automatic pix_t tri_top(tri_t t);
    return t[3*PIX_W-1 -: PIX_W];
  endfunction

  function automatic pix_t tri_mid(tri_t t);
    return t[2*PIX_W-1 -: PIX_W];
  endfunction

  function automatic pix_t tri_bot(tri_t t);
    return t[PIX_W-1:0];
  endfunction

  // Moves a column triple up by one row and replicates the bottom pixel.
  function automatic tri_t shift_down(tri_t t);
    return {tri_mid(t), tri_bot(t), tri_bot(t)};
  endfunction

  function automatic acc_t pix_diff(pix_t a, pix_t b);
    acc_t ea;
    acc_t eb;
    ea = $signed({{(GRAD_W+1-PIX_W){1'b0}}, a});
    eb = $signed({{(GRAD_W+1-PIX_W){1'b0}}, b});
    return ea - eb;
  endfunction

  function automatic grad_t sobel_eval(tri_t l, tri_t c, tri_t r, dir_t d);
    acc_t acc;
    if (d == DIR_DX) begin
      acc = pix_diff(tri_top(r), tri_top(l)) + (pix_diff(tri_mid(r), tri_mid(l)) <<< 1) +
            pix_diff(tri_bot(r), tri_bot(l));
    end else begin
      acc = pix_diff(tri_bot(l), tri_top(l)) + (pix_diff(tri_bot(c), tri_top(c)) <<< 1) +
            pix_diff(tri_bot(r), tri_top(r));
    end
    return acc[GRAD_W-1:0];
  endfunction

endpackage

/* src/sgs_if.sv */
// Valid/ready channel interfaces for pixel items and gradient result items.
interface sgs_pix_if;
  import sgs_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel;
  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface sgs_res_if;
  import sgs_pkg::*;
  logic  valid;
  logic  ready;
  grad_t gradient;
  logic  row_end;
  logic  frame_end;
  logic  last_of_run;
  modport source(output valid, output gradient, output row_end, output frame_end,
                 output last_of_run, input ready);
  modport sink(input valid, input gradient, input row_end, input frame_end,
               input last_of_run, output ready);
endinterface

/* src/sgs_line_store.sv */
// Line store memory holding the two previous rows, one write and one registered read port.
module sgs_line_store #(
  parameter int DEPTH = 2048
) (
  input  logic                                           clk,
  input  logic                                           rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
  output logic [sgs_pkg::LINE_W-1:0]                     rd_data,
  input  logic                                           wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
  input  logic [sgs_pkg::LINE_W-1:0]                     wr_data
);
  import sgs_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/sgs_window.sv */
// Three-column window and the four candidate Sobel results of one pixel.
module sgs_window (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          fire,
  input  sgs_pkg::pos_t                                 pos,
  input  sgs_pkg::pix_t                                 cur,
  input  sgs_pkg::pix_t                                 prev_px,
  input  sgs_pkg::pix_t                                 older_px,
  input  sgs_pkg::dir_t                                 dir,
  output sgs_pkg::res_t [sgs_pkg::RES_SLOTS-1:0]        res,
  output logic [sgs_pkg::RES_SLOTS-1:0]                 res_valid
);
  import sgs_pkg::*;

  tri_t win0_r, win1_r, win2_r;
  tri_t win0_nxt, win1_nxt, win2_nxt;
  tri_t col;
  pix_t top_px, mid_px;
  logic seen_later;

  always_comb begin
    if (pos.top_row) begin
      mid_px = cur;
      top_px = cur;
    end else begin
      mid_px = prev_px;
      top_px = pos.has_older ? older_px : prev_px;
    end
    col = {top_px, mid_px, cur};
    if (pos.first_col) begin
      win0_nxt = col;
      win1_nxt = col;
      win2_nxt = col;
    end else begin
      win0_nxt = win1_r;
      win1_nxt = win2_r;
      win2_nxt = col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
    end else if (fire) begin
      win0_r <= win0_nxt;
      win1_r <= win1_nxt;
      win2_r <= win2_nxt;
    end
  end

  // Results of the row above come first, then those of the bottom row on the last row.
  always_comb begin
    res_valid[0] = !pos.top_row && !pos.first_col;
    res_valid[1] = !pos.top_row && pos.row_end;
    res_valid[2] = pos.last_row && !pos.first_col;
    res_valid[3] = pos.last_row && pos.row_end;

    res[0].gradient = sobel_eval(win0_nxt, win1_nxt, win2_nxt, dir);
    res[1].gradient = sobel_eval(win1_nxt, win2_nxt, win2_nxt, dir);
    res[2].gradient = sobel_eval(shift_down(win0_nxt), shift_down(win1_nxt),
                                 shift_down(win2_nxt), dir);
    res[3].gradient = sobel_eval(shift_down(win1_nxt), shift_down(win2_nxt),
                                 shift_down(win2_nxt), dir);
    res[0].row_end   = 1'b0;
    res[1].row_end   = 1'b1;
    res[2].row_end   = 1'b0;
    res[3].row_end   = 1'b1;
    res[0].frame_end = 1'b0;
    res[1].frame_end = 1'b0;
    res[2].frame_end = 1'b0;
    res[3].frame_end = 1'b1;

    seen_later = 1'b0;
    for (int k = RES_SLOTS - 1; k >= 0; k--) begin
      res[k].last_of_run = res_valid[k] && !seen_later;
      seen_later = seen_later | res_valid[k];
    end
  end

endmodule

/* src/sgs_result_fifo.sv */
// Result queue; takes up to four items at once, delivers one per ready cycle.
module sgs_result_fifo (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     wr_en,
  input  sgs_pkg::res_t [sgs_pkg::RES_SLOTS-1:0]   wr_data,
  input  logic [sgs_pkg::RES_SLOTS-1:0]            wr_valid,
  output logic                                     room,
  sgs_res_if.source                                out
);
  import sgs_pkg::*;

  localparam int PW = $clog2(RES_FIFO_DEPTH);
  localparam int CW = $clog2(RES_FIFO_DEPTH + 1);
  localparam int NW = $clog2(RES_SLOTS + 1);

  res_t mem [RES_FIFO_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] slot [RES_SLOTS];
  logic [NW-1:0] n_wr;
  logic          pop;

  always_comb begin
    n_wr = '0;
    for (int k = 0; k < RES_SLOTS; k++) begin
      slot[k] = wptr_r + PW'(n_wr);
      n_wr = n_wr + NW'(wr_valid[k]);
    end
  end

  assign pop       = out.valid && out.ready;
  assign wptr_nxt  = wr_en ? wptr_r + PW'(n_wr) : wptr_r;
  assign rptr_nxt  = pop ? rptr_r + PW'(1) : rptr_r;
  assign count_nxt = count_r + (wr_en ? CW'(n_wr) : CW'(0)) - CW'(pop);
  assign room      = count_r <= CW'(RES_FIFO_DEPTH - RES_SLOTS);

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_SLOTS; k++) begin
      if (wr_en && wr_valid[k]) begin
        mem[slot[k]] <= wr_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  assign out.valid       = count_r != '0;
  assign out.gradient    = mem[rptr_r].gradient;
  assign out.row_end     = mem[rptr_r].row_end;
  assign out.frame_end   = mem[rptr_r].frame_end;
  assign out.last_of_run = mem[rptr_r].last_of_run;

endmodule

/* src/sobel3x3_gradient_stream_unit.sv */
// Top level of the streaming 3x3 Sobel gradient unit with replicated borders.
//
// Pixels enter in raster order on in_pix, one item per clock when the result side keeps
// up. Each pixel causes zero to four gradient items on out_res: none on the first row
// unless it is also the last, one for the row above once the column index is at least
// one, one more for the right edge at the end of a row, and on the last row the bottom
// row's results as well, with bottom replication. The accepted pixel's column reads a
// 2-entry-wide line store (the two rows above) at the accept edge; the registered
// compute stage then builds the column triple, shifts the three-column window, writes
// the line store back and pushes its results into an 8-entry result queue. The input
// stalls only while the queue has fewer than four free entries, so the sustained rate
// is one pixel per clock, bounded by the output's one result per clock on the extra
// right-edge results and on the last row, which gives two per pixel. A write to
// frame_width or frame_height restarts the frame; the user must see that configuration
// is written only while the unit is idle, as the unit itself does not enforce it. Sizes
// of zero act as one and sizes above MAX_WIDTH or MAX_HEIGHT act as that maximum.
// The line store has no clearing pass: entries are only used once the frame wrote them.
module sobel3x3_gradient_stream_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgs_pkg::CFG_W-1:0]         cfg_data,
  sgs_pix_if.sink                           in_pix,
  sgs_res_if.source                         out_res
);
  import sgs_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Index of the last column or row for a written size, with zero treated as one.
  function automatic int size_last(logic [CFG_W-1:0] v, int maxv);
    int r;
    if (v == '0) begin
      r = 0;
    end else if (int'(v) > maxv) begin
      r = maxv - 1;
    end else begin
      r = int'(v) - 1;
    end
    return r;
  endfunction

  // Configuration.
  logic [XW-1:0] w_last_r, w_last_nxt;
  logic [YW-1:0] h_last_r, h_last_nxt;
  dir_t          dir_r, dir_nxt;
  logic          size_write;

  // Frame position of the next pixel to be accepted.
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;

  // Compute stage.
  logic          s1_valid_r, s1_valid_nxt;
  pix_t          s1_pix_r;
  logic [XW-1:0] s1_x_r;
  pos_t          s1_pos_r, in_pos;

  // Forwarding of a line store write to a read of the same column in the same cycle.
  logic          byp_r, byp_nxt;
  pix_t          byp_prev_r, byp_older_r;

  logic          in_fire, s1_fire, fifo_room;
  logic [LINE_W-1:0] line_rd, line_wr;
  pix_t          prev_eff, older_eff;
  res_t [RES_SLOTS-1:0] cand;
  logic [RES_SLOTS-1:0] cand_valid;

  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    dir_nxt    = dir_r;
    size_write = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          w_last_nxt = XW'(size_last(cfg_data, MAX_WIDTH));
          size_write = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          h_last_nxt = YW'(size_last(cfg_data, MAX_HEIGHT));
          size_write = 1'b1;
        end
        REG_DIRECTION: begin
          dir_nxt = dir_t'(cfg_data[0]);
        end
        default: begin
        end
      endcase
    end
  end

  assign s1_fire      = s1_valid_r && fifo_room;
  assign in_pix.ready = !s1_valid_r || fifo_room;
  assign in_fire      = in_pix.valid && in_pix.ready;

  always_comb begin
    in_pos.first_col = col_r == '0;
    in_pos.row_end   = col_r == w_last_r;
    in_pos.top_row   = row_r == '0;
    in_pos.has_older = row_r > YW'(1);
    in_pos.last_row  = row_r == h_last_r;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (size_write) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (in_pos.row_end) begin
        col_nxt = '0;
        row_nxt = in_pos.last_row ? '0 : row_r + YW'(1);
      end else begin
        col_nxt = col_r + XW'(1);
      end
    end
  end

  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);
  assign byp_nxt      = in_fire && s1_fire && (s1_x_r == col_r);

  // The line store word holds the older row in the high byte.
  assign prev_eff  = byp_r ? byp_prev_r  : line_rd[PIX_W-1:0];
  assign older_eff = byp_r ? byp_older_r : line_rd[LINE_W-1 -: PIX_W];
  assign line_wr   = {prev_eff, s1_pix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r   <= XW'(size_last(CFG_W'(640), MAX_WIDTH));
      h_last_r   <= YW'(size_last(CFG_W'(480), MAX_HEIGHT));
      dir_r      <= DIR_DX;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      w_last_r   <= w_last_nxt;
      h_last_r   <= h_last_nxt;
      dir_r      <= dir_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        byp_r <= byp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r    <= in_pix.pixel;
      s1_x_r      <= col_r;
      s1_pos_r    <= in_pos;
      byp_prev_r  <= s1_pix_r;
      byp_older_r <= prev_eff;
    end
  end

  sgs_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (line_rd),
    .wr_en   (s1_fire),
    .wr_addr (s1_x_r),
    .wr_data (line_wr)
  );

  sgs_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .pos       (s1_pos_r),
    .cur       (s1_pix_r),
    .prev_px   (prev_eff),
    .older_px  (older_eff),
    .dir       (dir_r),
    .res       (cand),
    .res_valid (cand_valid)
  );

  sgs_result_fifo u_result_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (s1_fire),
    .wr_data  (cand),
    .wr_valid (cand_valid),
    .room     (fifo_room),
    .out      (out_res)
  );

  // The frame's last result closes both its row and its run of results.
  a_frame_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.frame_end |-> out_res.row_end && out_res.last_of_run)
    else $error("frame_end result without row_end or last_of_run");

  // The last pixel of a frame wraps the position back to the origin.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_pos.row_end && in_pos.last_row && !cfg_we |=> col_r == '0 && row_r == '0)
    else $error("position did not wrap at frame end");

  // Forwarding is only needed when consecutive pixels share a column.
  a_bypass_width_one: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && byp_r |-> w_last_r == '0)
    else $error("line store forwarding with a frame wider than one column");

  // A stalled compute stage keeps its item.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !fifo_room |=> s1_valid_r && $stable(s1_x_r) && $stable(s1_pix_r))
    else $error("compute stage lost its item while stalled");

endmodule
